// File: hw/rtl/osws_pkg.sv
// Shared types and constants of the obstacle-steering wheel-speed block.
package osws_pkg;

  // Configuration port
  localparam int AddrW = 5;
  localparam int DataW = 32;

  typedef enum logic [2:0] {
    REG_MAX_SPEED   = 3'd0,
    REG_SIDE_GAIN   = 3'd1,
    REG_CENTRE_GAIN = 3'd2,
    REG_CENTRE_NEAR = 3'd3,
    REG_CENTRE_CLOSE = 3'd4,
    REG_STILL_LIMIT = 3'd5,
    REG_STILL_X     = 3'd6,
    REG_STILL_Y     = 3'd7
  } reg_idx_e;

  typedef struct packed {
    logic [14:0] max_speed;
    logic [15:0] side_gain;
    logic [15:0] centre_gain;
    logic [7:0]  centre_near_mm;
    logic [7:0]  centre_close_mm;
    logic [7:0]  still_limit;
    logic [13:0] still_x_mg;
    logic [13:0] still_y_mg;
  } cfg_t;

  localparam logic [14:0] MaxSpeedRst   = 15'd4424;
  localparam logic [15:0] SideGainRst   = 16'd4096;
  localparam logic [15:0] CentreGainRst = 16'd12288;
  localparam logic [7:0]  CentreNearRst = 8'd130;
  localparam logic [7:0]  CentreCloseRst = 8'd50;
  localparam logic [7:0]  StillLimitRst = 8'd10;
  localparam logic [13:0] StillXRst     = 14'd600;
  localparam logic [13:0] StillYRst     = 14'd1200;

  // Steering modes, as carried on the result channel
  typedef enum logic [1:0] {
    MODE_WANDER = 2'd0,
    MODE_LEFT   = 2'd1,
    MODE_RIGHT  = 2'd2,
    MODE_CLOSE  = 2'd3
  } steer_mode_e;

  // Speeds
  localparam logic signed [15:0] RightDriveRst = 16'sd2212;
  localparam int SpeedOne = 16384;
  localparam logic [7:0] NoTarget = 8'd255;

  // Shared constant divider: dividend bits, bits retired per cycle
  localparam int DivW     = 21;
  localparam int DivBits  = 3;
  localparam int DivIters = DivW / DivBits;
  localparam int DivCntW  = $clog2(DivIters);
  localparam int DvsrW    = 7;

  localparam logic [DvsrW-1:0] Dvsr25  = DvsrW'(25);
  localparam logic [DvsrW-1:0] Dvsr35  = DvsrW'(35);
  localparam logic [DvsrW-1:0] Dvsr8   = DvsrW'(8);
  localparam logic [DvsrW-1:0] Dvsr120 = DvsrW'(120);

  // Controller to datapath
  typedef struct packed {
    logic cap;     // capture input beat
    logic eval;    // stillness, mode, gain product, digit product
    logic prep;    // load divider
    logic step;    // one divider iteration
    logic commit;  // update drive, load result register
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;  // result register can take a new beat
  } dp_stat_t;

endpackage

// File: hw/rtl/osws_cfg.sv
// Configuration register file behind the APB-style port.
module osws_cfg (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [osws_pkg::AddrW-1:0]    paddr,
  input  logic [osws_pkg::DataW-1:0]    pwdata,
  output logic [osws_pkg::DataW-1:0]    prdata,
  output logic                          pready,
  output osws_pkg::cfg_t                cfg_o
);
  import osws_pkg::*;

  cfg_t     cfg_q;
  reg_idx_e idx;
  logic     wr_en;

  assign pready = 1'b1;
  assign idx    = reg_idx_e'(paddr[AddrW-1:2]);
  assign wr_en  = psel & penable & pwrite & pready;
  assign cfg_o  = cfg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.max_speed       <= MaxSpeedRst;
      cfg_q.side_gain       <= SideGainRst;
      cfg_q.centre_gain     <= CentreGainRst;
      cfg_q.centre_near_mm  <= CentreNearRst;
      cfg_q.centre_close_mm <= CentreCloseRst;
      cfg_q.still_limit     <= StillLimitRst;
      cfg_q.still_x_mg      <= StillXRst;
      cfg_q.still_y_mg      <= StillYRst;
    end else if (wr_en) begin
      unique case (idx)
        REG_MAX_SPEED:    cfg_q.max_speed       <= pwdata[14:0];
        REG_SIDE_GAIN:    cfg_q.side_gain       <= pwdata[15:0];
        REG_CENTRE_GAIN:  cfg_q.centre_gain     <= pwdata[15:0];
        REG_CENTRE_NEAR:  cfg_q.centre_near_mm  <= pwdata[7:0];
        REG_CENTRE_CLOSE: cfg_q.centre_close_mm <= pwdata[7:0];
        REG_STILL_LIMIT:  cfg_q.still_limit     <= pwdata[7:0];
        REG_STILL_X:      cfg_q.still_x_mg      <= pwdata[13:0];
        REG_STILL_Y:      cfg_q.still_y_mg      <= pwdata[13:0];
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_MAX_SPEED:    prdata = DataW'(cfg_q.max_speed);
      REG_SIDE_GAIN:    prdata = DataW'(cfg_q.side_gain);
      REG_CENTRE_GAIN:  prdata = DataW'(cfg_q.centre_gain);
      REG_CENTRE_NEAR:  prdata = DataW'(cfg_q.centre_near_mm);
      REG_CENTRE_CLOSE: prdata = DataW'(cfg_q.centre_close_mm);
      REG_STILL_LIMIT:  prdata = DataW'(cfg_q.still_limit);
      REG_STILL_X:      prdata = DataW'(cfg_q.still_x_mg);
      REG_STILL_Y:      prdata = DataW'(cfg_q.still_y_mg);
    endcase
  end

endmodule

// File: hw/rtl/osws_ctrl.sv
// Sequencer: capture, evaluate, divide, commit.
module osws_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  output osws_pkg::dp_cmd_t  cmd_o,
  input  osws_pkg::dp_stat_t stat_i
);
  import osws_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EVAL,
    ST_PREP,
    ST_DIV,
    ST_COMMIT
  } state_e;

  state_e             state_q;
  logic [DivCntW-1:0] cnt_q;

  assign in_ready_o = (state_q == ST_IDLE);

  always_comb begin
    cmd_o        = '0;
    cmd_o.cap    = (state_q == ST_IDLE) & in_valid_i;
    cmd_o.eval   = (state_q == ST_EVAL);
    cmd_o.prep   = (state_q == ST_PREP);
    cmd_o.step   = (state_q == ST_DIV);
    cmd_o.commit = (state_q == ST_COMMIT) & stat_i.out_free;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) state_q <= ST_EVAL;
        end
        ST_EVAL: begin
          state_q <= ST_PREP;
        end
        ST_PREP: begin
          cnt_q   <= '0;
          state_q <= ST_DIV;
        end
        ST_DIV: begin
          cnt_q <= cnt_q + 1'b1;
          if (cnt_q == DivCntW'(DivIters - 1)) state_q <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (stat_i.out_free) state_q <= ST_IDLE;
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: hw/rtl/osws_dp.sv
// Datapath: input register, mode choice, gain product, constant divider, drive update.
module osws_dp (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  osws_pkg::cfg_t      cfg_i,
  input  osws_pkg::dp_cmd_t   cmd_i,
  output osws_pkg::dp_stat_t  stat_o,
  input  logic [7:0]          left_range_i,
  input  logic [7:0]          centre_range_i,
  input  logic [7:0]          right_range_i,
  input  logic                range_event_i,
  input  logic signed [14:0]  accel_x_mg_i,
  input  logic signed [14:0]  accel_y_mg_i,
  input  logic [3:0]          random_digit_i,
  output logic                out_valid_o,
  input  logic                out_ready_i,
  output logic signed [15:0]  left_speed_o,
  output logic signed [15:0]  right_speed_o,
  output logic                reverse_pulse_o,
  output logic [1:0]          steer_mode_o
);
  import osws_pkg::*;

  localparam logic signed [22:0] SatHi23 = 23'(SpeedOne);
  localparam logic signed [22:0] SatLo23 = -23'(SpeedOne);
  localparam logic signed [17:0] SatHi18 = 18'(SpeedOne);
  localparam logic signed [17:0] SatLo18 = -18'(SpeedOne);

  // Captured beat
  logic [7:0]         l_q, c_q, r_q;
  logic               ev_q;
  logic signed [14:0] ax_q, ay_q;
  logic [3:0]         dig_q;

  // State
  logic signed [15:0] drive_q;
  logic [7:0]         still_cnt_q;

  // Evaluation results
  steer_mode_e        mode_q, mode_d;
  logic               near_q, pulse_q;
  logic [31:0]        prod_q;
  logic [18:0]        dm_q;

  // Divider
  logic [DivW-1:0]    quo_q, quo_d;
  logic [DvsrW-1:0]   rem_q, rem_d;
  logic [DvsrW-1:0]   dvsr_q, dvsr_d;
  logic               neg_q, neg_d;
  logic [DivW-1:0]    dvnd_d;

  // Result register
  logic               out_vld_q;
  logic signed [15:0] left_q, right_q;
  logic               rev_q;
  steer_mode_e        omode_q;

  // Evaluation
  logic [14:0] ax_mag, ay_mag;
  logic        still, near;
  logic [7:0]  still_cnt_d;

  always_comb begin
    ax_mag      = ax_q[14] ? 15'(-ax_q) : 15'(ax_q);
    ay_mag      = ay_q[14] ? 15'(-ay_q) : 15'(ay_q);
    still       = (ax_mag < {1'b0, cfg_i.still_x_mg}) && (ay_mag < {1'b0, cfg_i.still_y_mg});
    still_cnt_d = still ? ((still_cnt_q == 8'hFF) ? still_cnt_q : still_cnt_q + 1'b1) : 8'd0;
    near        = c_q < cfg_i.centre_near_mm;
    mode_d      = MODE_WANDER;
    if (ev_q) begin
      priority if (near && (c_q < cfg_i.centre_close_mm)) mode_d = MODE_CLOSE;
      else if ((l_q >= r_q) && (r_q != NoTarget))        mode_d = MODE_RIGHT;
      else if (r_q > l_q)                                 mode_d = MODE_LEFT;
      else                                                mode_d = MODE_WANDER;
    end
  end

  // Divider set-up: magnitude, divisor and sign of the drive correction
  logic signed [17:0] two_r, m_ext, dev;
  logic [16:0]        dev_mag;
  logic               dev_big;
  logic signed [20:0] num, dm_ext, r8;
  logic [19:0]        num_mag;

  always_comb begin
    two_r   = {drive_q[15], drive_q, 1'b0};
    m_ext   = {3'b000, cfg_i.max_speed};
    dev     = two_r - m_ext;
    dev_mag = dev[17] ? 17'(-dev) : 17'(dev);
    dev_big = (21'({dev_mag, 3'b000}) + 21'(dev_mag)) > 21'({cfg_i.max_speed, 1'b0});
    dm_ext  = {2'b00, dm_q};
    r8      = {{2{drive_q[15]}}, drive_q, 3'b000};
    num     = dm_ext - r8;
    num_mag = num[20] ? 20'(-num) : 20'(num);

    unique case (mode_q)
      MODE_LEFT, MODE_RIGHT: begin
        // gain/100: prod/102400 = (prod/4096)/25
        dvnd_d = near_q ? DivW'(prod_q[31:12]) : DivW'(cfg_i.side_gain);
        dvsr_d = Dvsr25;
        neg_d  = (mode_q == MODE_RIGHT);
      end
      MODE_CLOSE: begin
        // gain/70: prod/71680 = (prod/2048)/35
        dvnd_d = near_q ? DivW'(prod_q[31:11]) : DivW'({cfg_i.side_gain, 1'b0});
        dvsr_d = Dvsr35;
        neg_d  = 1'b1;
      end
      MODE_WANDER: begin
        if (dev_big) begin
          dvnd_d = DivW'(dev_mag);
          dvsr_d = Dvsr8;
          neg_d  = ~dev[17];
        end else begin
          dvnd_d = DivW'(num_mag);
          dvsr_d = Dvsr120;
          neg_d  = num[20];
        end
      end
    endcase
  end

  // Restoring division, DivBits quotient bits per cycle on a narrow remainder
  logic [DvsrW:0] trial;

  always_comb begin
    quo_d = quo_q;
    rem_d = rem_q;
    trial = '0;
    for (int i = 0; i < DivBits; i++) begin
      trial = {rem_d, quo_d[DivW-1]};
      quo_d = {quo_d[DivW-2:0], 1'b0};
      if (trial >= {1'b0, dvsr_q}) begin
        rem_d    = DvsrW'(trial - {1'b0, dvsr_q});
        quo_d[0] = 1'b1;
      end else begin
        rem_d = trial[DvsrW-1:0];
      end
    end
  end

  // Drive update and left speed
  logic signed [22:0] sum;
  logic signed [15:0] drive_d;
  logic signed [17:0] left_w;
  logic signed [15:0] left_d;

  always_comb begin
    sum = neg_q ? (23'(drive_q) - signed'({2'b00, quo_q}))
                : (23'(drive_q) + signed'({2'b00, quo_q}));
    priority if (sum > SatHi23) drive_d = 16'(SatHi23);
    else if (sum < SatLo23)     drive_d = 16'(SatLo23);
    else                        drive_d = 16'(sum);
    left_w = m_ext - 18'(drive_d);
    priority if (left_w > SatHi18) left_d = 16'(SatHi18);
    else if (left_w < SatLo18)     left_d = 16'(SatLo18);
    else                           left_d = 16'(left_w);
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.cap) begin
      l_q   <= left_range_i;
      c_q   <= centre_range_i;
      r_q   <= right_range_i;
      ev_q  <= range_event_i;
      ax_q  <= accel_x_mg_i;
      ay_q  <= accel_y_mg_i;
      dig_q <= random_digit_i;
    end
    if (cmd_i.eval) begin
      mode_q  <= mode_d;
      near_q  <= near;
      pulse_q <= (still_cnt_d == cfg_i.still_limit);
      prod_q  <= cfg_i.side_gain * cfg_i.centre_gain;
      dm_q    <= dig_q * cfg_i.max_speed;
    end
    if (cmd_i.prep) begin
      quo_q  <= dvnd_d;
      rem_q  <= '0;
      dvsr_q <= dvsr_d;
      neg_q  <= neg_d;
    end else if (cmd_i.step) begin
      quo_q <= quo_d;
      rem_q <= rem_d;
    end
    if (cmd_i.commit) begin
      left_q  <= left_d;
      right_q <= drive_d;
      rev_q   <= pulse_q;
      omode_q <= mode_q;
    end
  end

  // Control and state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      drive_q     <= RightDriveRst;
      still_cnt_q <= '0;
      out_vld_q   <= 1'b0;
    end else begin
      if (cmd_i.eval)   still_cnt_q <= still_cnt_d;
      if (cmd_i.commit) drive_q     <= drive_d;
      if (cmd_i.commit)     out_vld_q <= 1'b1;
      else if (out_ready_i) out_vld_q <= 1'b0;
    end
  end

  assign stat_o.out_free = ~out_vld_q | out_ready_i;
  assign out_valid_o     = out_vld_q;
  assign left_speed_o    = left_q;
  assign right_speed_o   = right_q;
  assign reverse_pulse_o = rev_q;
  assign steer_mode_o    = omode_q;

endmodule

// File: hw/rtl/obstacle_steer_wheel_speed.sv
// Top level of the obstacle-steering wheel-speed controller.
//
//  channel   dir  handshake                  payload
//  s_axis    in   tvalid/tready              tdata: ranges, accel, digit; tuser: range event
//  m_axis    out  tvalid/tready              tdata: speeds, reverse pulse; tuser: steer mode
//  apb       in   psel/penable/pwrite/pready 8 registers at byte address 4*index
//
// One control tick runs from input beat to result: capture, evaluate
// (stillness, mode, 16x16 gain product, digit product), divider load, the iterations of the
// shared 3-bit-per-cycle constant divider, then commit. The next beat is taken
// the cycle after commit, so a new beat is never taken while a tick is in flight.
// Reset restores the configuration registers, right drive 2212 and a zero stillness count.
// The result sits in an output register; a stalled master holds only the commit
// step, and a fresh input beat is taken while the last result waits.
module obstacle_steer_wheel_speed (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  // input stream
  input  logic                       s_axis_tvalid,
  output logic                       s_axis_tready,
  // [7:0] left_range, [15:8] centre_range, [23:16] right_range,
  // [38:24] accel_x_mg, [53:39] accel_y_mg, [57:54] random_digit, [63:58] zero
  input  logic [63:0]                s_axis_tdata,
  // [0] range_event
  input  logic                       s_axis_tuser,
  // result stream
  output logic                       m_axis_tvalid,
  input  logic                       m_axis_tready,
  // [15:0] left_speed, [31:16] right_speed, [32] reverse_pulse, [39:33] zero
  output logic [39:0]                m_axis_tdata,
  // [1:0] steer_mode
  output logic [1:0]                 m_axis_tuser,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [osws_pkg::AddrW-1:0] paddr,
  input  logic [osws_pkg::DataW-1:0] pwdata,
  output logic [osws_pkg::DataW-1:0] prdata,
  output logic                       pready
);
  import osws_pkg::*;

  cfg_t     cfg;
  dp_cmd_t  cmd;
  dp_stat_t stat;

  logic signed [15:0] left_speed, right_speed;
  logic               reverse_pulse;

  osws_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  osws_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  osws_dp u_dp (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_i           (cfg),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .left_range_i    (s_axis_tdata[7:0]),
    .centre_range_i  (s_axis_tdata[15:8]),
    .right_range_i   (s_axis_tdata[23:16]),
    .range_event_i   (s_axis_tuser),
    .accel_x_mg_i    (s_axis_tdata[38:24]),
    .accel_y_mg_i    (s_axis_tdata[53:39]),
    .random_digit_i  (s_axis_tdata[57:54]),
    .out_valid_o     (m_axis_tvalid),
    .out_ready_i     (m_axis_tready),
    .left_speed_o    (left_speed),
    .right_speed_o   (right_speed),
    .reverse_pulse_o (reverse_pulse),
    .steer_mode_o    (m_axis_tuser)
  );

  assign m_axis_tdata = {7'b0, reverse_pulse, right_speed, left_speed};

endmodule
